// ===== rtl/quality_weighted_level_damper_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quality weighted level damper
// Clocked, reset-qualified property checks reporting through $error.
// ----------------------------------------------------------------------------
`ifndef QUALITY_WEIGHTED_LEVEL_DAMPER_TOP_ASSERT_SVH
`define QUALITY_WEIGHTED_LEVEL_DAMPER_TOP_ASSERT_SVH

// generic form: explicit clock and active-low reset
`define QWLD_ASSERT_CR(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// house form: clk_i / rst_ni of the enclosing module
`define QWLD_ASSERT(label, prop, msg) \
  `QWLD_ASSERT_CR(label, clk_i, rst_ni, prop, msg)

`endif

// ===== rtl/qwld_pkg.sv =====
// ----------------------------------------------------------------------------
// qwld_pkg
// Shared widths, register indexes and reset values of the level damper.
// ----------------------------------------------------------------------------
package qwld_pkg;

  // field widths
  localparam int unsigned CodeW    = 8;
  localparam int unsigned QualW    = 8;
  localparam int unsigned MinW     = 11;
  localparam int unsigned WeightW  = 17;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegNodata   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegUndetect = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinLevel = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRampStrt = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRampRcp  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegWtFloor  = 3'd5;

  // Q16 constants
  localparam logic [WeightW-1:0] Q16One  = 17'h10000;
  localparam logic [15:0]        Q16Half = 16'h8000;

  // reset values
  localparam logic [CodeW-1:0]   RstNodata   = 8'd255;
  localparam logic [CodeW-1:0]   RstUndetect = 8'd0;
  localparam logic [MinW-1:0]    RstMinLevel = 11'd0;
  localparam logic [QualW-1:0]   RstRampStrt = 8'd128;
  localparam logic [WeightW-1:0] RstRampRcp  = 17'd1024;
  localparam logic [WeightW-1:0] RstWtFloor  = 17'd0;

  typedef logic [CodeW-1:0]   code_t;
  typedef logic [WeightW-1:0] weight_t;

endpackage

// ===== rtl/qwld_if.sv =====
// ----------------------------------------------------------------------------
// Level damper channels
// Valid/ready channels for pixel words, result words and register writes.
// ----------------------------------------------------------------------------

// pixel and quality word
interface qwld_in_if import qwld_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t pixel_value;
  logic [QualW-1:0] quality_sample;

  modport source (output valid, output pixel_value, output quality_sample, input ready);
  modport sink   (input valid, input pixel_value, input quality_sample, output ready);
endinterface

// damped result word
interface qwld_out_if import qwld_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t damped_value;

  modport source (output valid, output damped_value, input ready);
  modport sink   (input valid, input damped_value, output ready);
endinterface

// register write word
interface qwld_cfg_if import qwld_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/quality_weighted_level_damper_top.sv =====
// ----------------------------------------------------------------------------
// Quality weighted level damper
// Path: an accepted pixel word moves through stages 1 to 4 to its result word on out_o.
// Throughput: one word per cycle while out_o is ready; four register stages, each with its own
//   valid bit, each stalling only when it is full and the next one is too.
// Reset: asynchronous, active low; clears the stage valid bits and loads the
//   register defaults. Register writes are taken every cycle.
// ----------------------------------------------------------------------------
module quality_weighted_level_damper_top
  import qwld_pkg::*;
#(
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  qwld_cfg_if.sink     cfg_i,
  qwld_in_if.sink      in_i,
  qwld_out_if.source   out_o
);

  localparam logic [16:0] PixMax  = 17'((33'd1 << PIXEL_BITS) - 33'd1);
  localparam logic [7:0]  PixMask = PixMax[7:0];

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  code_t            nodata_q, undetect_q;
  logic [MinW-1:0]  min_level_q;
  logic [QualW-1:0] ramp_start_q;
  weight_t          ramp_rcp_q, wt_floor_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodata_q     <= RstNodata;
      undetect_q   <= RstUndetect;
      min_level_q  <= RstMinLevel;
      ramp_start_q <= RstRampStrt;
      ramp_rcp_q   <= RstRampRcp;
      wt_floor_q   <= RstWtFloor;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegNodata:   nodata_q     <= cfg_i.data[CodeW-1:0];
        RegUndetect: undetect_q   <= cfg_i.data[CodeW-1:0];
        RegMinLevel: min_level_q  <= cfg_i.data[MinW-1:0];
        RegRampStrt: ramp_start_q <= cfg_i.data[QualW-1:0];
        RegRampRcp:  ramp_rcp_q   <= cfg_i.data[WeightW-1:0];
        RegWtFloor:  wt_floor_q   <= cfg_i.data[WeightW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage enables: a stage loads when it is empty or its word moves on
  // --------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q;
  logic en1, en2, en3, en4;

  assign en4 = !s4_v_q || out_o.ready;
  assign en3 = !s3_v_q || en4;
  assign en2 = !s2_v_q || en3;
  assign en1 = !s1_v_q || en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q <= in_i.valid;
      if (en2) s2_v_q <= s1_v_q;
      if (en3) s3_v_q <= s2_v_q;
      if (en4) s4_v_q <= s3_v_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: code match, quality offset, pixel offset from the floor
  // --------------------------------------------------------------------------
  code_t              pix;
  logic signed [11:0] pix_s, min_s, dist_s;
  logic               pass_d, below_d, gt_d;
  logic [QualW-1:0]   qdiff_d;

  logic               s1_pass_q, s1_below_q;
  code_t              s1_pix_q;
  logic [MinW-1:0]    s1_dist_q;
  logic [QualW-1:0]   s1_qdiff_q;

  always_comb begin
    pix     = in_i.pixel_value & PixMask;
    pix_s   = signed'({4'b0, pix});
    min_s   = signed'({min_level_q[MinW-1], min_level_q});
    dist_s  = pix_s - min_s;
    below_d = pix_s < min_s;
    pass_d  = (pix == nodata_q) || (pix == undetect_q);
    gt_d    = in_i.quality_sample > ramp_start_q;
    qdiff_d = gt_d ? (in_i.quality_sample - ramp_start_q) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      s1_pass_q  <= pass_d;
      s1_below_q <= below_d;
      s1_pix_q   <= pix;
      s1_dist_q  <= dist_s[MinW-1:0];  // in 0..1279 whenever it is used
      s1_qdiff_q <= qdiff_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: ramp weight, clamped to one
  // --------------------------------------------------------------------------
  logic [QualW+WeightW-1:0] ramp_prod;
  weight_t                  weight_d;

  logic                     s2_pass_q, s2_below_q;
  code_t                    s2_pix_q;
  logic [MinW-1:0]          s2_dist_q;
  weight_t                  s2_weight_q;

  always_comb begin
    ramp_prod = s1_qdiff_q * ramp_rcp_q;
    weight_d  = (ramp_prod > {8'b0, Q16One}) ? Q16One : ramp_prod[WeightW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_pass_q   <= s1_pass_q;
      s2_below_q  <= s1_below_q;
      s2_pix_q    <= s1_pix_q;
      s2_dist_q   <= s1_dist_q;
      s2_weight_q <= weight_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: floor test and weight times pixel offset
  // --------------------------------------------------------------------------
  logic                     s3_pass_q, s3_undet_q;
  code_t                    s3_pix_q;
  logic [WeightW+MinW-1:0]  s3_prod_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      s3_pass_q  <= s2_pass_q;
      s3_undet_q <= s2_below_q || (s2_weight_q < wt_floor_q);
      s3_pix_q   <= s2_pix_q;
      s3_prod_q  <= s2_weight_q * s2_dist_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: add floor, round half up, clamp, select result word
  // --------------------------------------------------------------------------
  logic signed [29:0] num;
  logic [13:0]        res;
  logic [16:0]        clamped;
  code_t              result_d;
  code_t              s4_value_q;

  always_comb begin
    num = signed'({{3{min_level_q[MinW-1]}}, min_level_q, 16'b0})
        + signed'({2'b0, s3_prod_q})
        + signed'({14'b0, Q16Half});
    res     = num[29] ? '0 : num[29:16];
    clamped = ({3'b0, res} > PixMax) ? PixMax : {3'b0, res};
    if (s3_pass_q) begin
      result_d = s3_pix_q;
    end else if (s3_undet_q) begin
      result_d = undetect_q;
    end else begin
      result_d = clamped[CodeW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      s4_value_q <= result_d;
    end
  end

  assign out_o.valid        = s4_v_q;
  assign out_o.damped_value = s4_value_q;

endmodule

// ===== rtl/qwld_checker.sv =====
// ----------------------------------------------------------------------------
// qwld_checker
// Port-level checks on the level damper: word hold, occupancy and stalls.
// ----------------------------------------------------------------------------
`include "quality_weighted_level_damper_top_assert.svh"

module qwld_checker
  import qwld_pkg::*;
(
  input logic  clk_i,
  input logic  rst_ni,
  input logic  in_valid_i,
  input logic  in_ready_i,
  input logic  out_valid_i,
  input logic  out_ready_i,
  input code_t out_value_i
);

  localparam logic [2:0] Depth = 3'd4;

  logic       in_take, out_take;
  logic [2:0] occ_q, occ_d;

  assign in_take  = in_valid_i && in_ready_i;
  assign out_take = out_valid_i && out_ready_i;

  // words accepted but not yet delivered
  always_comb begin
    occ_d = occ_q;
    if (in_take && !out_take) occ_d = occ_q + 3'd1;
    if (!in_take && out_take) occ_d = occ_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  `QWLD_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i), "result word dropped or changed while stalled")
  `QWLD_ASSERT(a_no_invent, out_valid_i |-> occ_q != 3'd0, "result word without an accepted pixel word")
  `QWLD_ASSERT(a_bounded, occ_q <= Depth, "more words in flight than pipeline stages")
  `QWLD_ASSERT(a_full_stall, occ_q == Depth && !out_take |-> !in_ready_i, "input taken while every stage is full")

endmodule

bind quality_weighted_level_damper_top qwld_checker u_qwld_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.damped_value)
);

// ===== dv/tb_quality_weighted_level_damper_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for quality_weighted_level_damper_top
// Drives pixel/quality words with bursty pacing and a patterned output stall,
// predicts each damped word from a shadow copy of the registers and checks
// every result in order. Registers are only rewritten once the pipe is empty.
// ----------------------------------------------------------------------------
module tb_quality_weighted_level_damper_top;
  import qwld_pkg::*;

  localparam int unsigned PixelBits    = 8;
  localparam longint      PixelMax     = (longint'(1) << PixelBits) - 1;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandomPhases = 14;
  localparam int unsigned PhaseWords   = 100;

  // indexes past the end of the register map
  localparam logic [CfgIdxW-1:0] SpareIdxLo = 3'd6;
  localparam logic [CfgIdxW-1:0] SpareIdxHi = 3'd7;

  typedef struct {
    code_t            damped;
    code_t            pixel;
    logic [QualW-1:0] quality;
  } damped_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  qwld_cfg_if cfg_if ();
  qwld_in_if  in_if ();
  qwld_out_if out_if ();

  quality_weighted_level_damper_top #(
    .PIXEL_BITS(PixelBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #6 clk_i = ~clk_i;

  // shadow of the block's registers
  code_t                   shadow_nodata;
  code_t                   shadow_undetect;
  logic signed [MinW-1:0]  shadow_min_level;
  logic [QualW-1:0]        shadow_ramp_start;
  weight_t                 shadow_ramp_gain;
  weight_t                 shadow_wt_floor;

  damped_word_t pending_damped[$];
  damped_word_t head_word;
  damped_word_t new_word;
  int unsigned  error_count;
  int unsigned  quiet_cycles;

  // sender pacing
  int burst_left;
  int gap_max;

  // receiver stall pattern
  logic [15:0] stall_pat;
  int          stall_age;

  // Expected damped word for one pixel under the current register values
  function automatic code_t predict_damped(input code_t pix, input logic [QualW-1:0] qual);
    longint weight;
    longint level;
    longint acc;
    level  = shadow_min_level;
    weight = 0;
    if (pix == shadow_nodata || pix == shadow_undetect) return pix;
    // linear quality ramp, clamped to one
    if (qual > shadow_ramp_start)
      weight = longint'(qual - shadow_ramp_start) * longint'(shadow_ramp_gain);
    if (weight > longint'(Q16One)) weight = longint'(Q16One);
    if (weight < longint'(shadow_wt_floor) || longint'(pix) < level) return shadow_undetect;
    // blend toward the floor level, round half up, clamp to pixel range
    acc = level * longint'(Q16One) + weight * (longint'(pix) - level) + longint'(Q16Half);
    if (acc < 0) return '0;
    acc = acc >>> 16;
    if (acc > PixelMax) acc = PixelMax;
    return code_t'(acc);
  endfunction

  function automatic void load_shadow(input logic [CfgIdxW-1:0] idx,
                                      input logic [CfgDataW-1:0] data);
    case (idx)
      RegNodata:   shadow_nodata     = data[CodeW-1:0];
      RegUndetect: shadow_undetect   = data[CodeW-1:0];
      RegMinLevel: shadow_min_level  = data[MinW-1:0];
      RegRampStrt: shadow_ramp_start = data[QualW-1:0];
      RegRampRcp:  shadow_ramp_gain  = data[WeightW-1:0];
      RegWtFloor:  shadow_wt_floor   = data[WeightW-1:0];
      default: ;
    endcase
  endfunction

  // Scoreboard: retire the result first, then queue the new prediction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        if (pending_damped.size() == 0) begin
          $display("%0t: unexpected damped word, expected none, got %0d",
                   $time, out_if.damped_value);
          error_count++;
        end else begin
          head_word = pending_damped.pop_front();
          if (out_if.damped_value !== head_word.damped) begin
            $display("%0t: damped_value mismatch, expected %0d, got %0d (pixel %0d quality %0d)",
                     $time, head_word.damped, out_if.damped_value, head_word.pixel,
                     head_word.quality);
            error_count++;
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        new_word.pixel   = in_if.pixel_value;
        new_word.quality = in_if.quality_sample;
        new_word.damped  = predict_damped(in_if.pixel_value, in_if.quality_sample);
        pending_damped.push_back(new_word);
      end
    end
  end

  // Watchdog on cycles with no handshake anywhere
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QuietLimit) begin
      $display("quality_weighted_level_damper_top test failed");
      $finish;
    end
  end

  // Receiver: rotate a stall pattern, swapping in a new one when its age runs out
  always @(negedge clk_i) begin
    if (stall_age <= 0) begin
      if ($urandom_range(0, 2) == 0) stall_pat = '1;
      else stall_pat = 16'($urandom) | 16'h0001;
      stall_age = $urandom_range(20, 80);
    end
    out_if.ready <= stall_pat[0];
    stall_pat = {stall_pat[0], stall_pat[15:1]};
    stall_age--;
  end

  // One pixel word; valid stays high afterwards unless a gap follows
  task automatic send_pixel(input code_t pix, input logic [QualW-1:0] qual);
    int gap;
    gap = 0;
    if (burst_left <= 0) begin
      if (gap_max > 0) gap = $urandom_range(1, gap_max);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_if.valid          <= 1'b1;
    in_if.pixel_value    <= pix;
    in_if.quality_sample <= qual;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    burst_left--;
    @(negedge clk_i);
  endtask

  // Stop sending and wait until every damped word is back
  task automatic wait_results();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (pending_damped.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    load_shadow(idx, data);
    @(negedge clk_i);
  endtask

  // Full register set, written only with the pipe empty
  task automatic apply_settings(input logic [CfgDataW-1:0] nodata_w,
                                input logic [CfgDataW-1:0] undet_w,
                                input logic [CfgDataW-1:0] min_w,
                                input logic [CfgDataW-1:0] start_w,
                                input logic [CfgDataW-1:0] gain_w,
                                input logic [CfgDataW-1:0] floor_w);
    wait_results();
    write_reg(RegNodata, nodata_w);
    write_reg(RegUndetect, undet_w);
    write_reg(RegMinLevel, min_w);
    write_reg(RegRampStrt, start_w);
    write_reg(RegRampRcp, gain_w);
    write_reg(RegWtFloor, floor_w);
    cfg_if.valid <= 1'b0;
  endtask

  // Reset values: codes pass, ramp below, inside and above its span
  task automatic check_reset_settings();
    send_pixel(8'd0, 8'd255);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd100, 8'd128);
    send_pixel(8'd100, 8'd129);
    send_pixel(8'd200, 8'd192);
    send_pixel(8'd254, 8'd255);
  endtask

  // No-data and undetect codes, equal and distinct
  task automatic check_code_passthrough();
    apply_settings(17'd17, 17'h1FF11, 17'd0, 17'd0, 17'd65536, 17'd0);
    send_pixel(8'd17, 8'd0);
    send_pixel(8'd0, 8'd0);
    apply_settings(17'd200, 17'd50, 17'd0, 17'd0, 17'd65536, 17'd0);
    send_pixel(8'd200, 8'd255);
    send_pixel(8'd50, 8'd0);
    send_pixel(8'd255, 8'd255);
  endtask

  // Zero gain, out-of-range gain and floor, weight clamp
  task automatic check_ramp_limits();
    apply_settings(17'd255, 17'd9, 17'd0, 17'h1FF80, 17'd0, 17'd1);
    send_pixel(8'd100, 8'd255);
    apply_settings(17'd255, 17'd9, 17'd0, 17'd0, 17'h1FFFF, 17'd65536);
    send_pixel(8'd123, 8'd1);
    send_pixel(8'd123, 8'd0);
    apply_settings(17'd255, 17'd9, 17'd0, 17'd255, 17'h1FFFF, 17'h1FFFF);
    send_pixel(8'd77, 8'd255);
  endtask

  // Floor level at both extremes, pixel below it, negative blend clamp
  task automatic check_min_level();
    apply_settings(17'd255, 17'd3, 17'h1FC00, 17'd0, 17'd1, 17'd0);
    send_pixel(8'd1, 8'd0);
    send_pixel(8'd255, 8'd255);
    apply_settings(17'd255, 17'd3, 17'h1E3FF, 17'd0, 17'd65536, 17'd0);
    send_pixel(8'd254, 8'd255);
    apply_settings(17'd255, 17'd3, 17'd100, 17'd0, 17'd65536, 17'd0);
    send_pixel(8'd99, 8'd255);
    send_pixel(8'd150, 8'd0);
    apply_settings(17'd255, 17'd3, 17'h1FFFF, 17'd0, 17'd256, 17'd0);
    send_pixel(8'd2, 8'd1);
  endtask

  // Writes past the register map must not disturb anything
  task automatic check_spare_index();
    wait_results();
    write_reg(SpareIdxLo, 17'h1FFFF);
    write_reg(SpareIdxHi, 17'($urandom));
    cfg_if.valid <= 1'b0;
    send_pixel(8'd2, 8'd3);
    send_pixel(8'd180, 8'd200);
  endtask

  // Random register sets, each followed by a run of random words
  task automatic run_random_phases();
    logic [CfgDataW-1:0] nodata_w, undet_w, min_w, start_w, gain_w, floor_w;
    code_t               pix;
    int                  qual;
    int                  level;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      nodata_w = 17'($urandom);
      undet_w  = ($urandom_range(0, 9) == 0) ? nodata_w : 17'($urandom);
      min_w    = 17'($urandom);
      case ($urandom_range(0, 3))
        0: ;
        1: min_w[MinW-1:0] = 11'($urandom_range(0, 160));
        2: min_w[MinW-1:0] = 11'(-$urandom_range(1, 64));
        default: min_w[MinW-1:0] = 11'($urandom_range(0, 40));
      endcase
      start_w = 17'($urandom);
      start_w[QualW-1:0] = 8'($urandom_range(0, 200));
      case ($urandom_range(0, 5))
        0: gain_w = 17'd0;
        1: gain_w = 17'd65536;
        2: gain_w = 17'($urandom);
        default: gain_w = 17'($urandom_range(1, 4096));
      endcase
      case ($urandom_range(0, 4))
        0: floor_w = 17'($urandom);
        1, 2: floor_w = 17'($urandom_range(0, 65536));
        default: floor_w = 17'd0;
      endcase
      apply_settings(nodata_w, undet_w, min_w, start_w, gain_w, floor_w);
      gap_max = (ph == 0) ? 0 : $urandom_range(0, 6);
      for (int n = 0; n < PhaseWords; n++) begin
        level = shadow_min_level;
        case ($urandom_range(0, 9))
          0: pix = shadow_nodata;
          1: pix = shadow_undetect;
          2, 3: begin
            // straddle the floor level where it lies in pixel range
            level = level + $urandom_range(0, 8) - 4;
            if (level < 0) level = 0;
            if (level > 255) level = 255;
            pix = code_t'(level);
          end
          default: pix = code_t'($urandom);
        endcase
        // bias quality toward the low end of the ramp
        if ($urandom_range(0, 2) == 0) begin
          qual = int'(shadow_ramp_start) + $urandom_range(0, 8);
          if (qual > 255) qual = 255;
        end else begin
          qual = $urandom_range(0, 255);
        end
        send_pixel(pix, 8'(qual));
      end
    end
  endtask

  initial begin
    error_count  = 0;
    burst_left   = 0;
    gap_max      = 2;
    stall_age    = 0;
    stall_pat    = '1;
    rst_ni       = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    in_if.valid  = 1'b0;
    in_if.pixel_value    = '0;
    in_if.quality_sample = '0;
    out_if.ready = 1'b0;
    load_shadow(RegNodata, 17'(RstNodata));
    load_shadow(RegUndetect, 17'(RstUndetect));
    load_shadow(RegMinLevel, 17'(RstMinLevel));
    load_shadow(RegRampStrt, 17'(RstRampStrt));
    load_shadow(RegRampRcp, 17'(RstRampRcp));
    load_shadow(RegWtFloor, 17'(RstWtFloor));
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    check_reset_settings();
    check_code_passthrough();
    check_ramp_limits();
    check_min_level();
    check_spare_index();
    run_random_phases();

    wait_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0)
      $display("quality_weighted_level_damper_top test passed");
    else
      $display("quality_weighted_level_damper_top test failed");
    $finish;
  end

endmodule
